@@ hdl/pr_pkg.sv @@
// ---------------------------------------------------------------------------
// pr_pkg: shared constants and types of the PageRank power iteration block
// Widths of the node index, rank values and the command and status words
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pr_pkg;

  // Node count and derived index width
  localparam int NODES  = 4;
  localparam int NODE_W = $clog2(NODES);

  // Unsigned Q0.24 values, one extra bit to hold 1.0 itself
  localparam int FRAC_W = 24;
  localparam int RANK_W = FRAC_W + 1;
  localparam logic [RANK_W-1:0] ONE = RANK_W'(1 << FRAC_W);
  localparam logic [RANK_W-1:0] INIT_RANK = RANK_W'((1 << FRAC_W) / NODES);

  // Product, row accumulator and L1 distance widths
  localparam int PROD_W = 2 * RANK_W;
  localparam int ACC_W  = PROD_W + $clog2(NODES);
  localparam int DIST_W = RANK_W + $clog2(NODES);

  // Iteration counter and configuration port
  localparam int ITER_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = CFG_IDX_W'(1);
  localparam logic [RANK_W-1:0] TOL_RESET  = RANK_W'(168);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1000);

  // Controller to datapath commands
  typedef struct packed {
    logic              load;   // input word accepted
    logic              start;  // last element taken, begin a run
    logic              mul;    // register one product
    logic              acc;    // add the product into the row sum
    logic              row;    // finish one row of the next vector
    logic              check;  // close one iteration
    logic              clear;  // wipe the matrix store
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] c;
    logic [NODE_W-1:0] node;
  } pr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv;     // L1 distance below tolerance
    logic cap_hit;  // this iteration reaches the cap
  } pr_status_t;

endpackage

@@ hdl/pagerank_power_iteration.sv @@
// ---------------------------------------------------------------------------
// pagerank_power_iteration: PageRank by power iteration over a link matrix
// Top level joining the sequencer and the datapath.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one matrix element word per
//   cycle while in_stall_o is low: row, col, weight (Q0.24, clamped to 1.0)
//   and last. Elements with last low give no result. The word with last high
//   is stored and starts a run from a uniform rank of 1/NODES.
//   Each iteration uses one shared multiplier: one product then one add per
//   element, plus a row finish per row and a final check.
//   The run ends when the L1 distance drops below tolerance or the cap of
//   max_iterations (0 acts as 1) is reached; then NODES result words follow,
//   node 0 first, with last_node_o high on the final one.
//   in_stall_o stays high from the last element until the final result word
//   is taken. A stall on out_stall_i holds the current result word.
//   The matrix store is cleared after the final result word is taken.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready: index 0 is the
//   tolerance, index 1 the iteration cap; write it only while idle.
//   Reset clears the matrix store and ranks and loads tolerance 168 and a
//   cap of 1000.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pagerank_power_iteration import pr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           row_i,
  input  logic [1:0]           col_i,
  input  logic [24:0]          weight_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           node_o,
  output logic [24:0]          rank_o,
  output logic                 converged_o,
  output logic [15:0]          iterations_o,
  output logic                 last_node_o
);

  pr_cmd_t    cmd;
  pr_status_t status;

  pr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .node_o      (node_o),
    .last_node_o (last_node_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .weight_i     (weight_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .rank_o       (rank_o),
    .converged_o  (converged_o),
    .iterations_o (iterations_o)
  );

endmodule

@@ hdl/pr_ctrl.sv @@
// ---------------------------------------------------------------------------
// pr_ctrl: sequencer of the PageRank power iteration
// Walks load, multiply, accumulate, row finish, iteration check and result
// emission, and drives the handshakes of both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pr_ctrl import pr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NODE_W-1:0] node_o,
  output logic              last_node_o,
  input  pr_status_t        status_i,
  output pr_cmd_t           cmd_o
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(NODES - 1);

  logic [2:0]        state_q, state_d;
  logic [NODE_W-1:0] r_q, r_d;
  logic [NODE_W-1:0] c_q, c_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic              in_acc;
  logic              out_acc;

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = (state_q == S_EMIT);
  assign node_o      = node_q;
  assign last_node_o = (node_q == LAST_IDX);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Next state and counters
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    node_d  = node_q;
    cmd_o   = '0;
    cmd_o.r    = r_q;
    cmd_o.c    = c_q;
    cmd_o.node = node_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            cmd_o.start = 1'b1;
            r_d     = '0;
            c_d     = '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (c_q == LAST_IDX) begin
          state_d = S_ROW;
        end else begin
          c_d     = c_q + NODE_W'(1);
          state_d = S_MUL;
        end
      end
      S_ROW: begin
        cmd_o.row = 1'b1;
        c_d       = '0;
        if (r_q == LAST_IDX) begin
          state_d = S_CHECK;
        end else begin
          r_d     = r_q + NODE_W'(1);
          state_d = S_MUL;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        r_d         = '0;
        if (status_i.conv || status_i.cap_hit) begin
          node_d  = '0;
          state_d = S_EMIT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (node_q == LAST_IDX) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            node_d = node_q + NODE_W'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      r_q     <= '0;
      c_q     <= '0;
      node_q  <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      node_q  <= node_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input ready while results are pending");
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_i) |=> (state_q == S_MUL && r_q == '0 && c_q == '0))
    else $error("run did not start after last element");
  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_node_o) |=> !in_stall_o)
    else $error("input not reopened after final result");
  a_emit_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && state_d == S_EMIT) |=> (node_q == '0))
    else $error("results do not start at node zero");
`endif

endmodule

@@ hdl/pr_datapath.sv @@
// ---------------------------------------------------------------------------
// pr_datapath: matrix store, rank vectors and arithmetic
// One registered 25x25 multiplier feeds a row accumulator; row sums are
// saturated and folded into an L1 distance checked against the tolerance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pr_datapath import pr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic [NODE_W-1:0]    row_i,
  input  logic [NODE_W-1:0]    col_i,
  input  logic [RANK_W-1:0]    weight_i,
  input  pr_cmd_t              cmd_i,
  output pr_status_t           status_o,
  output logic [RANK_W-1:0]    rank_o,
  output logic                 converged_o,
  output logic [ITER_W-1:0]    iterations_o
);

  logic [RANK_W-1:0] mtx_q [NODES][NODES];
  logic [RANK_W-1:0] cur_q [NODES];
  logic [RANK_W-1:0] nxt_q [NODES];
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q;
  logic [DIST_W-1:0] dist_q;
  logic [ITER_W-1:0] iter_q;
  logic              conv_q;
  logic [RANK_W-1:0] tol_q;
  logic [ITER_W-1:0] max_q;

  logic [RANK_W-1:0]     w_sat;
  logic                  in_range;
  logic [ACC_W-FRAC_W-1:0] shifted;
  logic [RANK_W-1:0]     row_val;
  logic [RANK_W-1:0]     cur_r;
  logic [RANK_W-1:0]     abs_diff;
  logic [ITER_W-1:0]     cap;

  assign cfg_ready_o = 1'b1;

  // Clamp the weight and drop elements outside the matrix
  assign w_sat    = (weight_i > ONE) ? ONE : weight_i;
  assign in_range = (32'(row_i) < NODES) && (32'(col_i) < NODES);

  // Saturate the finished row sum and take its distance to the current rank
  assign shifted  = acc_q[ACC_W-1:FRAC_W];
  assign row_val  = (shifted > (ACC_W-FRAC_W)'(ONE)) ? ONE : shifted[RANK_W-1:0];
  assign cur_r    = cur_q[cmd_i.r];
  assign abs_diff = (row_val >= cur_r) ? (row_val - cur_r) : (cur_r - row_val);

  // Status toward the controller
  assign cap              = (max_q == '0) ? ITER_W'(1) : max_q;
  assign status_o.conv    = dist_q < DIST_W'(tol_q);
  assign status_o.cap_hit = ({1'b0, iter_q} + (ITER_W+1)'(1)) >= {1'b0, cap};

  assign rank_o       = cur_q[cmd_i.node];
  assign converged_o  = conv_q;
  assign iterations_o = iter_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      max_q <= ITER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_TOLERANCE) begin
        tol_q <= cfg_data_i[RANK_W-1:0];
      end else if (cfg_index_i == CFG_MAX_ITER) begin
        max_q <= cfg_data_i[ITER_W-1:0];
      end
    end
  end

  // Matrix store: write on load, wipe after a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        for (int j = 0; j < NODES; j++) begin
          mtx_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < NODES; i++) begin
        for (int j = 0; j < NODES; j++) begin
          mtx_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.load && in_range) begin
      mtx_q[row_i][col_i] <= w_sat;
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(mtx_q[cmd_i.r][cmd_i.c]) * PROD_W'(cur_q[cmd_i.c]);
    end
  end

  // Rank vectors, accumulators and iteration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        cur_q[i] <= '0;
        nxt_q[i] <= '0;
      end
      acc_q  <= '0;
      dist_q <= '0;
      iter_q <= '0;
      conv_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        for (int i = 0; i < NODES; i++) begin
          cur_q[i] <= INIT_RANK;
        end
        acc_q  <= '0;
        dist_q <= '0;
        iter_q <= '0;
      end
      if (cmd_i.acc) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
      if (cmd_i.row) begin
        nxt_q[cmd_i.r] <= row_val;
        dist_q         <= dist_q + DIST_W'(abs_diff);
        acc_q          <= '0;
      end
      if (cmd_i.check) begin
        for (int i = 0; i < NODES; i++) begin
          cur_q[i] <= nxt_q[i];
        end
        iter_q <= iter_q + ITER_W'(1);
        conv_q <= status_o.conv;
        dist_q <= '0;
      end
    end
  end

endmodule

@@ tb/sv/tb_pagerank_power_iteration.sv @@
// ---------------------------------------------------------------------------
// tb_pagerank_power_iteration: self-checking bench for the PageRank block
// Loads link matrices word by word, runs power iterations under several
// tolerance and cap settings, and checks every rank word against directed
// values or the in-bench model. Input gaps and output stalls are random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pagerank_power_iteration;
  import pr_pkg::*;

  // Cycles per iteration with one shared multiplier
  localparam int ITER_CYCLES    = NODES * (2 * NODES + 1) + 1;
  localparam int MAX_RAND_CAP   = 60;
  localparam int WATCHDOG_LIMIT = 4 * (MAX_RAND_CAP * ITER_CYCLES + 256);
  localparam int SETTLE_CYCLES  = 2 * NODES * NODES;
  localparam int TAIL_CYCLES    = 4 * NODES * NODES;
  localparam int RAND_ITEMS     = 90;

  // One line of the stimulus plan: a matrix element or a register write
  typedef struct packed {
    logic                         is_cfg;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DAT_W-1:0]         cfg_data;
    logic [1:0]                   row;
    logic [1:0]                   col;
    logic [RANK_W-1:0]            weight;
    logic                         last;
    logic                         typed;
    logic [NODES-1:0][RANK_W-1:0] exp_rank;
    logic                         exp_conv;
    logic [ITER_W-1:0]            exp_iters;
  } plan_row_t;

  // One rank word as it leaves the block
  typedef struct packed {
    logic [1:0]        node;
    logic [RANK_W-1:0] rank;
    logic              conv;
    logic [ITER_W-1:0] iters;
    logic              last_node;
  } rank_word_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           row_i;
  logic [1:0]           col_i;
  logic [24:0]          weight_i;
  logic                 last_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           node_o;
  logic [24:0]          rank_o;
  logic                 converged_o;
  logic [15:0]          iterations_o;
  logic                 last_node_o;

  // Model state and configuration
  logic [RANK_W-1:0] link_weight [NODES*NODES];
  logic [RANK_W-1:0] rank_now [NODES];
  logic [RANK_W-1:0] rank_next [NODES];
  logic [ITER_W-1:0] iter_count;
  logic [RANK_W-1:0] tol_reg;
  logic [ITER_W-1:0] cap_reg;
  rank_word_t        predicted [NODES];
  rank_word_t        pending_ranks [$];
  rank_word_t        want_word;

  // Bookkeeping
  int errors = 0;
  int elements_sent = 0;
  int runs_total = 0;
  int runs_conv = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  stall_tick = '0;

  pagerank_power_iteration DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_i        (row_i),
    .col_i        (col_i),
    .weight_i     (weight_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .node_o       (node_o),
    .rank_o       (rank_o),
    .converged_o  (converged_o),
    .iterations_o (iterations_o),
    .last_node_o  (last_node_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Build plan lines
  function automatic plan_row_t element_word(logic [1:0] r, logic [1:0] c,
                                             logic [RANK_W-1:0] w, logic l);
    plan_row_t p;
    p = '0;
    p.row = r;
    p.col = c;
    p.weight = w;
    p.last = l;
    return p;
  endfunction

  function automatic plan_row_t closing_word(logic [1:0] r, logic [1:0] c,
                                             logic [RANK_W-1:0] w,
                                             logic [RANK_W-1:0] r0, logic [RANK_W-1:0] r1,
                                             logic [RANK_W-1:0] r2, logic [RANK_W-1:0] r3,
                                             logic conv, logic [ITER_W-1:0] iters);
    plan_row_t p;
    p = element_word(r, c, w, 1'b1);
    p.typed = 1'b1;
    p.exp_rank[0] = r0;
    p.exp_rank[1] = r1;
    p.exp_rank[2] = r2;
    p.exp_rank[3] = r3;
    p.exp_conv = conv;
    p.exp_iters = iters;
    return p;
  endfunction

  function automatic plan_row_t reg_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.cfg_index = idx;
    p.cfg_data = val;
    return p;
  endfunction

  // Store one element; on the closing element run the power iteration
  function automatic bit take_element(plan_row_t it);
    logic [63:0]       acc;
    logic [63:0]       l1_sum;
    logic [ITER_W-1:0] cap;
    bit                conv;
    bit                done;
    link_weight[it.row * NODES + it.col] = (it.weight > ONE) ? ONE : it.weight;
    if (!it.last) return 1'b0;
    cap = (cap_reg == '0) ? ITER_W'(1) : cap_reg;
    for (int k = 0; k < NODES; k++) rank_now[k] = INIT_RANK;
    iter_count = '0;
    conv = 1'b0;
    done = 1'b0;
    while (!done) begin
      // next = M * current, truncated then saturated at 1.0
      for (int rr = 0; rr < NODES; rr++) begin
        acc = '0;
        for (int cc = 0; cc < NODES; cc++)
          acc += 64'(link_weight[rr * NODES + cc]) * 64'(rank_now[cc]);
        acc = acc >> FRAC_W;
        rank_next[rr] = (acc > 64'(ONE)) ? ONE : acc[RANK_W-1:0];
      end
      iter_count++;
      l1_sum = '0;
      for (int rr = 0; rr < NODES; rr++) begin
        if (rank_next[rr] >= rank_now[rr]) l1_sum += 64'(rank_next[rr] - rank_now[rr]);
        else l1_sum += 64'(rank_now[rr] - rank_next[rr]);
      end
      for (int rr = 0; rr < NODES; rr++) rank_now[rr] = rank_next[rr];
      // Convergence wins when the cap is hit on the same iteration
      if (l1_sum < 64'(tol_reg)) begin
        conv = 1'b1;
        done = 1'b1;
      end else if (iter_count >= cap) begin
        done = 1'b1;
      end
    end
    for (int k = 0; k < NODES; k++) begin
      predicted[k].node = 2'(k);
      predicted[k].rank = rank_now[k];
      predicted[k].conv = conv;
      predicted[k].iters = iter_count;
      predicted[k].last_node = (k == NODES - 1);
    end
    for (int k = 0; k < NODES * NODES; k++) link_weight[k] = '0;
    runs_total++;
    if (conv) runs_conv++;
    return 1'b1;
  endfunction

  // Drop valid and hold until every rank word is back and the store is clear
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_ranks.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    burst_left = 0;
  endtask

  // Send one element word; bursts of random length with random gaps
  task automatic send_element(plan_row_t it);
    int         gap;
    rank_word_t word;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    row_i <= it.row;
    col_i <= it.col;
    weight_i <= it.weight;
    last_i <= it.last;
    do @(posedge clk_i); while (in_stall_o);
    elements_sent++;
    if (take_element(it)) begin
      for (int k = 0; k < NODES; k++) begin
        word = predicted[k];
        if (it.typed) begin
          word.rank = it.exp_rank[k];
          word.conv = it.exp_conv;
          word.iters = it.exp_iters;
        end
        pending_ranks.push_back(word);
      end
    end
    @(negedge clk_i);
  endtask

  // Register write, only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TOLERANCE) tol_reg = val[RANK_W-1:0];
    else if (idx == CFG_MAX_ITER) cap_reg = val[ITER_W-1:0];
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [RANK_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONE;
      2:       return RANK_W'($urandom_range(32'(ONE) + 1, 32'h1FF_FFFF));
      default: return RANK_W'($urandom_range(0, 32'(ONE)));
    endcase
  endfunction

  function automatic logic [RANK_W-1:0] pick_tolerance();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ONE;
      2:       return RANK_W'(32'h1FF_FFFF);
      3:       return RANK_W'($urandom_range(0, 255));
      default: return RANK_W'($urandom_range(0, 32'h2_0000));
    endcase
  endfunction

  function automatic logic [ITER_W-1:0] pick_cap();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ITER_W'(1);
      default: return ITER_W'($urandom_range(2, MAX_RAND_CAP));
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Receiver stall pattern; a new mode is drawn at random when stall_tick[5:0] is zero
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 99) < 35);
      STALL_PERIODIC: out_stall_i <= (stall_tick[2:0] < 3'd3);
      default:        out_stall_i <= ($urandom_range(0, 15) == 0) ? ~out_stall_i : out_stall_i;
    endcase
  end

  // Compare each accepted rank word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ranks.size() == 0) begin
        $error("rank word for node %0d arrived with nothing expected", node_o);
        errors++;
      end else begin
        want_word = pending_ranks.pop_front();
        check_field("node", 32'(want_word.node), 32'(node_o));
        check_field("rank", 32'(want_word.rank), 32'(rank_o));
        check_field("converged", 32'(want_word.conv), 32'(converged_o));
        check_field("iterations", 32'(want_word.iters), 32'(iterations_o));
        check_field("last_node", 32'(want_word.last_node), 32'(last_node_o));
        words_checked++;
      end
    end
  end

  // Count cycles in which no word moves on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan [$];
    int        shape;
    int        n;
    int        rand_start;
    int        runs_left;
    logic [1:0] r;
    logic [1:0] c;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    row_i = '0;
    col_i = '0;
    weight_i = '0;
    last_i = 1'b0;
    tol_reg = TOL_RESET;
    cap_reg = ITER_RESET;
    iter_count = '0;
    for (int k = 0; k < NODES * NODES; k++) link_weight[k] = '0;
    for (int k = 0; k < NODES; k++) begin
      rank_now[k] = '0;
      rank_next[k] = '0;
    end

    // Hold reset, then release it on a falling clock edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan, reset settings first
    // zero matrix: all ranks drop to 0, distance 0 on the second pass
    plan.push_back(closing_word(2'd0, 2'd0, '0, '0, '0, '0, '0, 1'b1, ITER_W'(2)));
    // identity, weights above one clamp to one: fixed point at once
    plan.push_back(element_word(2'd0, 2'd0, ONE, 1'b0));
    plan.push_back(element_word(2'd1, 2'd1, ONE, 1'b0));
    plan.push_back(element_word(2'd2, 2'd2, RANK_W'(32'h1FF_FFFF), 1'b0));
    plan.push_back(closing_word(2'd3, 2'd3, RANK_W'(32'h1FF_FFFF),
                                INIT_RANK, INIT_RANK, INIT_RANK, INIT_RANK, 1'b1, ITER_W'(1)));
    // dense 2x2 block: row sums saturate at one on the third pass
    plan.push_back(element_word(2'd0, 2'd0, ONE, 1'b0));
    plan.push_back(element_word(2'd0, 2'd1, ONE, 1'b0));
    plan.push_back(element_word(2'd1, 2'd0, ONE, 1'b0));
    plan.push_back(closing_word(2'd1, 2'd1, ONE, ONE, ONE, '0, '0, 1'b1, ITER_W'(3)));
    // zero tolerance never converges; a zero cap acts as one
    plan.push_back(reg_word(CFG_TOLERANCE, '0));
    plan.push_back(reg_word(CFG_MAX_ITER, '0));
    plan.push_back(closing_word(2'd3, 2'd3, ONE, '0, '0, '0, INIT_RANK, 1'b0, ITER_W'(1)));
    // tolerance of one and the largest cap: converges on the first pass
    plan.push_back(reg_word(CFG_TOLERANCE, CFG_DAT_W'(ONE)));
    plan.push_back(reg_word(CFG_MAX_ITER, CFG_DAT_W'(16'hFFFF)));
    plan.push_back(closing_word(2'd1, 2'd2, ONE >> 1, '0, INIT_RANK >> 1, '0, '0,
                                1'b1, ITER_W'(1)));
    // convergence and cap on the same pass; upper data bits ignored
    plan.push_back(reg_word(CFG_TOLERANCE, CFG_DAT_W'(TOL_RESET)));
    plan.push_back(reg_word(CFG_MAX_ITER, {9'h1AB, 16'd2}));
    plan.push_back(closing_word(2'd2, 2'd1, '0, '0, '0, '0, '0, 1'b1, ITER_W'(2)));
    // mixed weights, checked by the model
    plan.push_back(reg_word(CFG_TOLERANCE, CFG_DAT_W'(32'h1000)));
    plan.push_back(reg_word(CFG_MAX_ITER, CFG_DAT_W'(20)));
    plan.push_back(element_word(2'd0, 2'd1, RANK_W'(32'h0AB_CDEF), 1'b0));
    plan.push_back(element_word(2'd1, 2'd0, RANK_W'(32'h0D5_5555), 1'b0));
    plan.push_back(element_word(2'd2, 2'd3, RANK_W'(32'h1FF_FFFF), 1'b0));
    plan.push_back(element_word(2'd3, 2'd2, RANK_W'(32'h080_0000), 1'b0));
    plan.push_back(element_word(2'd0, 2'd0, RANK_W'(32'h012_3456), 1'b1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].cfg_index, plan[i].cfg_data);
      else send_element(plan[i]);
    end

    // Random runs, new settings every few runs
    rand_start = elements_sent;
    runs_left = 0;
    while (elements_sent - rand_start < RAND_ITEMS) begin
      if (runs_left == 0) begin
        write_reg(CFG_TOLERANCE, pick_tolerance());
        write_reg(CFG_MAX_ITER, {($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'd0,
                                 pick_cap()});
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_IDX_W'($urandom_range(2, 3)), CFG_DAT_W'($urandom));
        runs_left = $urandom_range(2, 5);
      end
      runs_left--;
      // lone closing word, full dense matrix, or a sparse handful
      shape = $urandom_range(0, 9);
      if (shape == 0) n = 1;
      else if (shape == 1) n = NODES * NODES;
      else n = $urandom_range(2, 8);
      for (int k = 0; k < n; k++) begin
        if (shape == 1) begin
          r = 2'(k / NODES);
          c = 2'(k % NODES);
        end else begin
          r = 2'($urandom_range(0, 3));
          c = 2'($urandom_range(0, 3));
        end
        send_element(element_word(r, c, pick_weight(), k == n - 1));
      end
      if ($urandom_range(0, 5) == 0) settle();
    end

    // Drain and let the store clear
    in_valid_i <= 1'b0;
    while (pending_ranks.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d element words over %0d runs (%0d converged, %0d stopped at the cap).",
             elements_sent, runs_total, runs_conv, runs_total - runs_conv);
    $display("Checked %0d rank words after %0d register writes, with stalls on both sides.",
             words_checked, reg_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
